// ===== src/pvc_pkg.sv =====
package pvc_pkg;

  // Field widths and fixed-point positions.
  localparam int VEL_W     = 32;
  localparam int NORM_W    = 16;
  localparam int FAC_W     = 16;
  localparam int NORM_FRAC = 14;
  localparam int FAC_FRAC  = 12;
  localparam int WIDE_W    = 50;

  // Backoff division: dividend is a positive Q16.16 backoff times 4096.
  localparam int BK_DIV_N = VEL_W - 1 + FAC_FRAC;
  localparam int QUOT_W   = 32;

  // Squared lengths and their roots.
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;

  localparam logic [FAC_W-1:0] FACTOR_RESET = 16'd4100;
  localparam logic [FAC_W-1:0] FACTOR_MIN   = 16'd1;
  localparam logic [VEL_W-1:0] VEL_MAX      = 32'h7fff_ffff;

  // Payload that rides alongside the backoff divider.
  typedef struct packed {
    logic [2:0][VEL_W-1:0]  vel;
    logic [2:0][NORM_W-1:0] norm;
    logic                   is_neg;
    logic [VEL_W-1:0]       neg_back;
    logic                   ovf;
  } bk_side_t;

  // Payload that rides alongside the square roots and the rescale divider.
  typedef struct packed {
    logic [2:0][VEL_W-1:0] clip;
    logic                  grow;
  } len_side_t;

  // Saturate a wide signed value to the velocity range.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [WIDE_W-1:0] x);
    if (x > 50'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -50'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return $signed(x[VEL_W-1:0]);
    end
  endfunction

  // Magnitude of a signed velocity as an unsigned value.
  function automatic logic [VEL_W-1:0] mag_vel(input logic [VEL_W-1:0] x);
    return x[VEL_W-1] ? (32'd0 - x) : x;
  endfunction

endpackage

// ===== src/pvc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The caller guarantees dividend < divisor * 2^Q
// whenever the quotient is used.
module pvc_div #(
  parameter int N  = 64,
  parameter int D  = 32,
  parameter int Q  = 32,
  parameter int L  = 1,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [L-1:0][N-1:0]   in_dividend,
  input  logic [D-1:0]          in_divisor,
  input  logic [SW-1:0]         in_side,
  output logic                  out_valid,
  output logic [L-1:0][Q-1:0]   out_quot,
  output logic [SW-1:0]         out_side
);

  logic                valid_r   [Q+1];
  logic [L-1:0][D-1:0] rem_r     [Q+1];
  logic [L-1:0][Q-1:0] low_r     [Q+1];
  logic [L-1:0][Q-1:0] quot_r    [Q+1];
  logic [D-1:0]        divisor_r [Q+1];
  logic [SW-1:0]       side_r    [Q+1];

  logic                valid_nxt   [Q+1];
  logic [L-1:0][D-1:0] rem_nxt     [Q+1];
  logic [L-1:0][Q-1:0] low_nxt     [Q+1];
  logic [L-1:0][Q-1:0] quot_nxt    [Q+1];
  logic [D-1:0]        divisor_nxt [Q+1];
  logic [SW-1:0]       side_nxt    [Q+1];

  // Stage zero loads the operands; each later stage settles one quotient bit.
  always_comb begin
    logic [D:0] sh;
    sh = '0;
    valid_nxt[0]   = in_valid;
    divisor_nxt[0] = in_divisor;
    side_nxt[0]    = in_side;
    for (int l = 0; l < L; l++) begin
      rem_nxt[0][l]  = D'(in_dividend[l] >> Q);
      low_nxt[0][l]  = in_dividend[l][Q-1:0];
      quot_nxt[0][l] = '0;
    end
    for (int k = 0; k < Q; k++) begin
      valid_nxt[k+1]   = valid_r[k];
      divisor_nxt[k+1] = divisor_r[k];
      side_nxt[k+1]    = side_r[k];
      for (int l = 0; l < L; l++) begin
        sh = {rem_r[k][l], low_r[k][l][Q-1]};
        low_nxt[k+1][l] = low_r[k][l] << 1;
        if (sh >= {1'b0, divisor_r[k]}) begin
          rem_nxt[k+1][l]  = D'(sh - {1'b0, divisor_r[k]});
          quot_nxt[k+1][l] = Q'({quot_r[k][l], 1'b1});
        end else begin
          rem_nxt[k+1][l]  = sh[D-1:0];
          quot_nxt[k+1][l] = Q'({quot_r[k][l], 1'b0});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Q; k++) valid_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= Q; k++) valid_r[k] <= valid_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= Q; k++) begin
        rem_r[k]     <= rem_nxt[k];
        low_r[k]     <= low_nxt[k];
        quot_r[k]    <= quot_nxt[k];
        divisor_r[k] <= divisor_nxt[k];
        side_r[k]    <= side_nxt[k];
      end
    end
  end

  assign out_valid = valid_r[Q];
  assign out_quot  = quot_r[Q];
  assign out_side  = side_r[Q];

endmodule

// ===== src/pvc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, several lanes.
module pvc_sqrt #(
  parameter int L  = 2,
  parameter int SW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [L-1:0][pvc_pkg::SQ_W-1:0]   in_rad,
  input  logic [SW-1:0]                     in_side,
  output logic                              out_valid,
  output logic [L-1:0][pvc_pkg::ROOT_W-1:0] out_root,
  output logic [SW-1:0]                     out_side
);

  localparam int W = pvc_pkg::SQ_W;
  localparam int R = pvc_pkg::ROOT_W;

  logic                valid_r  [R+1];
  logic [L-1:0][W-1:0] rem_r    [R+1];
  logic [L-1:0][R-1:0] root_r   [R+1];
  logic [SW-1:0]       side_r   [R+1];

  logic                valid_nxt [R+1];
  logic [L-1:0][W-1:0] rem_nxt   [R+1];
  logic [L-1:0][R-1:0] root_nxt  [R+1];
  logic [SW-1:0]       side_nxt  [R+1];

  // Stage k tries root bit R-1-k against the remainder x - root^2.
  always_comb begin
    logic [W+1:0] trial;
    trial = '0;
    valid_nxt[0] = in_valid;
    side_nxt[0]  = in_side;
    for (int l = 0; l < L; l++) begin
      rem_nxt[0][l]  = in_rad[l];
      root_nxt[0][l] = '0;
    end
    for (int k = 0; k < R; k++) begin
      valid_nxt[k+1] = valid_r[k];
      side_nxt[k+1]  = side_r[k];
      for (int l = 0; l < L; l++) begin
        trial = ((W+2)'(root_r[k][l]) << (R - k)) | ((W+2)'(1) << (2 * (R - 1 - k)));
        if ((W+2)'(rem_r[k][l]) >= trial) begin
          rem_nxt[k+1][l]  = rem_r[k][l] - trial[W-1:0];
          root_nxt[k+1][l] = root_r[k][l] | (R'(1) << (R - 1 - k));
        end else begin
          rem_nxt[k+1][l]  = rem_r[k][l];
          root_nxt[k+1][l] = root_r[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= R; k++) valid_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= R; k++) valid_r[k] <= valid_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= R; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = valid_r[R];
  assign out_root  = root_r[R];
  assign out_side  = side_r[R];

endmodule

// ===== src/pvc_front.sv =====
// Dot product, backoff, and the operands of the backoff division.
module pvc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2:0][pvc_pkg::VEL_W-1:0]       in_vel,
  input  logic [2:0][pvc_pkg::NORM_W-1:0]      in_norm,
  input  logic [pvc_pkg::FAC_W-1:0]            factor,
  output logic                                 out_valid,
  output logic [pvc_pkg::BK_DIV_N-1:0]         out_dividend,
  output logic [pvc_pkg::FAC_W-1:0]            out_divisor,
  output pvc_pkg::bk_side_t                    out_side
);

  logic                               v1_r, v2_r, v3_r;
  logic [2:0][pvc_pkg::VEL_W-1:0]     vel1_r, vel2_r, vel3_r;
  logic [2:0][pvc_pkg::NORM_W-1:0]    norm1_r, norm2_r, norm3_r;
  logic signed [47:0]                 prod1_r [3];
  logic signed [47:0]                 prod1_nxt [3];
  logic signed [pvc_pkg::VEL_W-1:0]   back2_r;
  logic signed [pvc_pkg::VEL_W-1:0]   back2_nxt;
  logic signed [48:0]                 neg3_r, neg3_nxt;
  logic                               is_neg3_r, is_neg3_nxt;
  logic [pvc_pkg::BK_DIV_N-1:0]       dvd3_r, dvd3_nxt;
  logic [pvc_pkg::FAC_W-1:0]          dvs3_r, dvs3_nxt;

  // Stage 1: the three velocity-normal products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod1_nxt[i] = $signed(in_vel[i]) * $signed(in_norm[i]);
    end
  end

  // Stage 2: sum to the dot product and drop the normal's fraction bits.
  always_comb begin
    logic signed [pvc_pkg::WIDE_W-1:0] dot;
    dot = pvc_pkg::WIDE_W'(prod1_r[0]) + pvc_pkg::WIDE_W'(prod1_r[1])
        + pvc_pkg::WIDE_W'(prod1_r[2]);
    back2_nxt = pvc_pkg::sat_vel(dot >>> pvc_pkg::NORM_FRAC);
  end

  // Stage 3: overbounce product for a non-positive backoff, division
  // operands for a positive one.
  always_comb begin
    is_neg3_nxt = back2_r[pvc_pkg::VEL_W-1] || (back2_r == '0);
    neg3_nxt    = back2_r * $signed({1'b0, factor});
    dvd3_nxt    = {back2_r[pvc_pkg::VEL_W-2:0], {pvc_pkg::FAC_FRAC{1'b0}}};
    dvs3_nxt    = (factor == '0) ? pvc_pkg::FACTOR_MIN : factor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel1_r    <= in_vel;
      norm1_r   <= in_norm;
      prod1_r   <= prod1_nxt;
      vel2_r    <= vel1_r;
      norm2_r   <= norm1_r;
      back2_r   <= back2_nxt;
      vel3_r    <= vel2_r;
      norm3_r   <= norm2_r;
      neg3_r    <= neg3_nxt;
      is_neg3_r <= is_neg3_nxt;
      dvd3_r    <= dvd3_nxt;
      dvs3_r    <= dvs3_nxt;
    end
  end

  // The overbounce product is scaled and clamped on its way into the divider.
  always_comb begin
    out_side.vel      = vel3_r;
    out_side.norm     = norm3_r;
    out_side.is_neg   = is_neg3_r;
    out_side.neg_back = pvc_pkg::sat_vel(
                          $signed({neg3_r[48], neg3_r}) >>> pvc_pkg::FAC_FRAC);
    out_side.ovf      = {5'd0, dvd3_r[pvc_pkg::BK_DIV_N-1:pvc_pkg::QUOT_W]} >= dvs3_r;
  end

  assign out_valid    = v3_r;
  assign out_dividend = dvd3_r;
  assign out_divisor  = dvs3_r;

endmodule

// ===== src/pvc_clip.sv =====
// Removes normal times backoff from the velocity and compares squared speeds.
module pvc_clip (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [pvc_pkg::QUOT_W-1:0]      in_quot,
  input  pvc_pkg::bk_side_t               in_side,
  output logic                            out_valid,
  output logic [1:0][pvc_pkg::SQ_W-1:0]   out_rad,
  output pvc_pkg::len_side_t              out_side
);

  logic                            v1_r, v2_r, v3_r, v4_r;
  logic [2:0][pvc_pkg::VEL_W-1:0]  vel1_r, vel2_r;
  logic signed [47:0]              prod1_r [3];
  logic signed [47:0]              prod1_nxt [3];
  logic [2:0][pvc_pkg::VEL_W-1:0]  clip2_r, clip2_nxt, clip3_r, clip4_r;
  logic [pvc_pkg::SQ_W-1:0]        sqv3_r [3];
  logic [pvc_pkg::SQ_W-1:0]        sqo3_r [3];
  logic [pvc_pkg::SQ_W-1:0]        sqv3_nxt [3];
  logic [pvc_pkg::SQ_W-1:0]        sqo3_nxt [3];
  logic [pvc_pkg::SQ_W-1:0]        old4_r, old4_nxt, new4_r, new4_nxt;
  logic                            grow4_r;

  // Stage 1: pick the final backoff and scale each normal component by it.
  always_comb begin
    logic signed [pvc_pkg::VEL_W-1:0] back;
    if (in_side.is_neg) begin
      back = $signed(in_side.neg_back);
    end else if (in_side.ovf || in_quot[pvc_pkg::QUOT_W-1]) begin
      back = $signed(pvc_pkg::VEL_MAX);
    end else begin
      back = $signed(in_quot);
    end
    for (int i = 0; i < 3; i++) begin
      prod1_nxt[i] = $signed(in_side.norm[i]) * back;
    end
  end

  // Stage 2: subtract the change, clamped to the velocity range.
  always_comb begin
    logic signed [pvc_pkg::WIDE_W-1:0] diff;
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      diff = $signed(vel1_r[i]) - (prod1_r[i] >>> pvc_pkg::NORM_FRAC);
      clip2_nxt[i] = pvc_pkg::sat_vel(diff);
    end
  end

  // Stage 3: squares of the component magnitudes.
  always_comb begin
    logic [pvc_pkg::VEL_W-1:0] mv, mo;
    for (int i = 0; i < 3; i++) begin
      mv = pvc_pkg::mag_vel(vel2_r[i]);
      mo = pvc_pkg::mag_vel(clip2_r[i]);
      sqv3_nxt[i] = pvc_pkg::SQ_W'(mv) * pvc_pkg::SQ_W'(mv);
      sqo3_nxt[i] = pvc_pkg::SQ_W'(mo) * pvc_pkg::SQ_W'(mo);
    end
  end

  // Stage 4: squared lengths.
  assign old4_nxt = sqv3_r[0] + sqv3_r[1] + sqv3_r[2];
  assign new4_nxt = sqo3_r[0] + sqo3_r[1] + sqo3_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel1_r  <= in_side.vel;
      prod1_r <= prod1_nxt;
      vel2_r  <= vel1_r;
      clip2_r <= clip2_nxt;
      clip3_r <= clip2_r;
      sqv3_r  <= sqv3_nxt;
      sqo3_r  <= sqo3_nxt;
      clip4_r <= clip3_r;
      old4_r  <= old4_nxt;
      new4_r  <= new4_nxt;
      grow4_r <= new4_nxt > old4_nxt;
    end
  end

  assign out_valid     = v4_r;
  assign out_rad[0]    = old4_r;
  assign out_rad[1]    = new4_r;
  assign out_side.clip = clip4_r;
  assign out_side.grow = grow4_r;

endmodule

// ===== src/plane_velocity_clip.sv =====
// Clips a velocity against a plane with overbounce: the backoff is the dot
// product of the Q16.16 velocity with the Q2.14 normal, multiplied by the Q4.12
// overbounce factor when it is zero or less and divided by it otherwise, and
// normal times backoff is taken off the velocity, every step clamped to the
// signed 32-bit range. A result that came out longer than the input is scaled
// back to the input's length and flagged on out_tuser. One beat is taken per
// clock while the output buffer has a free entry; each result passes through
// three fully pipelined 32-step units in a row: the backoff divider, the pair
// of square roots of the squared lengths, and the rescale divider.
// A two-entry output buffer keeps in_tready registered while results wait.
module plane_velocity_clip (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // vel_x, vel_y, vel_z, norm_x, norm_y, norm_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // clip_x, clip_y, clip_z
  output logic [0:0]   out_tuser,  // speed_clamped
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data    // overbounce_factor
);

  localparam int BK_W  = $bits(pvc_pkg::bk_side_t);
  localparam int LEN_W = $bits(pvc_pkg::len_side_t);
  localparam int VW    = pvc_pkg::VEL_W;
  localparam int NW    = pvc_pkg::NORM_W;

  logic                                en;
  logic [pvc_pkg::FAC_W-1:0]           factor_r;
  logic [2:0][VW-1:0]                  in_vel;
  logic [2:0][NW-1:0]                  in_norm;

  logic                                fr_valid;
  logic [pvc_pkg::BK_DIV_N-1:0]        fr_dividend;
  logic [pvc_pkg::FAC_W-1:0]           fr_divisor;
  pvc_pkg::bk_side_t                   fr_side;

  logic                                bd_valid;
  logic [0:0][pvc_pkg::QUOT_W-1:0]     bd_quot;
  logic [BK_W-1:0]                     bd_side_bits;

  logic                                cl_valid;
  logic [1:0][pvc_pkg::SQ_W-1:0]       cl_rad;
  pvc_pkg::len_side_t                  cl_side;

  logic                                sq_valid;
  logic [1:0][pvc_pkg::ROOT_W-1:0]     sq_root;
  logic [LEN_W-1:0]                    sq_side_bits;
  pvc_pkg::len_side_t                  sq_side;

  logic                                sc_valid_r;
  logic [2:0][pvc_pkg::SQ_W-1:0]       sc_prod_r, sc_prod_nxt;
  logic [pvc_pkg::ROOT_W-1:0]          sc_len_r, sc_len_nxt;
  logic [LEN_W-1:0]                    sc_side_r;

  logic                                rd_valid;
  logic [2:0][pvc_pkg::QUOT_W-1:0]     rd_quot;
  logic [LEN_W-1:0]                    rd_side_bits;
  pvc_pkg::len_side_t                  rd_side;
  logic [96:0]                         pipe_beat;

  logic                                out_valid_r, out_valid_nxt;
  logic [96:0]                         out_beat_r, out_beat_nxt;
  logic                                skid_full_r, skid_full_nxt;
  logic [96:0]                         skid_beat_r, skid_beat_nxt;
  logic                                out_take;

  // Overbounce factor register; always ready for a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= pvc_pkg::FACTOR_RESET;
    end else if (cfg_valid) begin
      factor_r <= cfg_data;
    end
  end

  // The whole pipeline moves while the output buffer has a free entry.
  assign en        = !skid_full_r;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_vel[i]  = in_tdata[i*VW +: VW];
      in_norm[i] = in_tdata[3*VW + i*NW +: NW];
    end
  end

  pvc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .in_vel       (in_vel),
    .in_norm      (in_norm),
    .factor       (factor_r),
    .out_valid    (fr_valid),
    .out_dividend (fr_dividend),
    .out_divisor  (fr_divisor),
    .out_side     (fr_side)
  );

  // Positive backoff times 4096 divided by the factor.
  pvc_div #(
    .N  (pvc_pkg::BK_DIV_N),
    .D  (pvc_pkg::FAC_W),
    .Q  (pvc_pkg::QUOT_W),
    .L  (1),
    .SW (BK_W)
  ) u_back_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (fr_valid),
    .in_dividend (fr_dividend),
    .in_divisor  (fr_divisor),
    .in_side     (fr_side),
    .out_valid   (bd_valid),
    .out_quot    (bd_quot),
    .out_side    (bd_side_bits)
  );

  pvc_clip u_clip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (bd_valid),
    .in_quot   (bd_quot[0]),
    .in_side   (pvc_pkg::bk_side_t'(bd_side_bits)),
    .out_valid (cl_valid),
    .out_rad   (cl_rad),
    .out_side  (cl_side)
  );

  // Input and result lengths.
  pvc_sqrt #(
    .L  (2),
    .SW (LEN_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cl_valid),
    .in_rad    (cl_rad),
    .in_side   (cl_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side_bits)
  );

  assign sq_side = pvc_pkg::len_side_t'(sq_side_bits);

  // Scale stage: each result magnitude times the input length.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc_prod_nxt[i] = pvc_pkg::SQ_W'(pvc_pkg::mag_vel(sq_side.clip[i]))
                     * pvc_pkg::SQ_W'(sq_root[0]);
    end
    sc_len_nxt = (sq_root[1] == '0) ? pvc_pkg::ROOT_W'(1) : sq_root[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (en) begin
      sc_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_prod_r <= sc_prod_nxt;
      sc_len_r  <= sc_len_nxt;
      sc_side_r <= sq_side_bits;
    end
  end

  // Divide by the result length to land on the input length.
  pvc_div #(
    .N  (pvc_pkg::SQ_W),
    .D  (pvc_pkg::ROOT_W),
    .Q  (pvc_pkg::QUOT_W),
    .L  (3),
    .SW (LEN_W)
  ) u_len_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (sc_valid_r),
    .in_dividend (sc_prod_r),
    .in_divisor  (sc_len_r),
    .in_side     (sc_side_r),
    .out_valid   (rd_valid),
    .out_quot    (rd_quot),
    .out_side    (rd_side_bits)
  );

  assign rd_side = pvc_pkg::len_side_t'(rd_side_bits);

  // Restore signs on the rescaled components, or pass the clip through.
  always_comb begin
    pipe_beat[96] = rd_side.grow;
    for (int i = 0; i < 3; i++) begin
      if (!rd_side.grow) begin
        pipe_beat[i*VW +: VW] = rd_side.clip[i];
      end else if (rd_side.clip[i][VW-1]) begin
        pipe_beat[i*VW +: VW] = 32'd0 - rd_quot[i];
      end else begin
        pipe_beat[i*VW +: VW] = rd_quot[i];
      end
    end
  end

  // Output register with a skid entry behind it.
  assign out_take = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    skid_full_nxt = skid_full_r;
    skid_beat_nxt = skid_beat_r;
    if (out_take) begin
      if (skid_full_r) begin
        out_valid_nxt = 1'b1;
        out_beat_nxt  = skid_beat_r;
        skid_full_nxt = 1'b0;
      end else begin
        out_valid_nxt = rd_valid;
        out_beat_nxt  = pipe_beat;
      end
    end else if (!skid_full_r && rd_valid) begin
      skid_full_nxt = 1'b1;
      skid_beat_nxt = pipe_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r  <= out_beat_nxt;
    skid_beat_r <= skid_beat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r[95:0];
  assign out_tuser  = out_beat_r[96:96];

endmodule

// ===== test/plane_velocity_clip_check.sv =====
// Watches the input, result and register channels of the clipper, predicts
// each result from the accepted input beat and compares it with what leaves.
module plane_velocity_clip_check (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [95:0] clip;
    logic        clamped;
  } clip_res_t;

  logic [pvc_pkg::FAC_W-1:0] factor;
  clip_res_t                 clip_queue[$];

  // Saturate to the signed 32-bit velocity range.
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Floored integer square root, one result bit per step.
  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic clip_res_t clip_velocity(input logic [143:0] d,
                                              input logic [pvc_pkg::FAC_W-1:0] fac);
    longint v[3];
    longint n[3];
    longint o[3];
    longint dot;
    longint back;
    longint divisor;
    longint unsigned oldsq;
    longint unsigned newsq;
    longint unsigned ol;
    longint unsigned nl;
    longint unsigned m;
    clip_res_t r;
    dot = 0;
    oldsq = 0;
    newsq = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(d[32*i +: 32]));
      n[i] = longint'($signed(d[96 + 16*i +: 16]));
      dot += v[i] * n[i];
    end
    // Arithmetic right shift on a signed value floors.
    back = clamp32(dot >>> pvc_pkg::NORM_FRAC);
    if (back <= 0) begin
      back = clamp32((back * longint'(fac)) >>> pvc_pkg::FAC_FRAC);
    end else begin
      divisor = (fac == 0) ? 1 : longint'(fac);
      back = clamp32((back * 4096) / divisor);
    end
    for (int i = 0; i < 3; i++) begin
      o[i] = clamp32(v[i] - ((n[i] * back) >>> pvc_pkg::NORM_FRAC));
      oldsq += longint'(v[i] < 0 ? -v[i] : v[i]) ** 2;
      newsq += longint'(o[i] < 0 ? -o[i] : o[i]) ** 2;
    end
    r.clamped = newsq > oldsq;
    if (r.clamped) begin
      ol = root64(oldsq);
      nl = root64(newsq);
      if (nl == 0) nl = 1;
      for (int i = 0; i < 3; i++) begin
        m = (longint'(o[i] < 0 ? -o[i] : o[i]) * ol) / nl;
        o[i] = o[i] < 0 ? -longint'(m) : longint'(m);
      end
    end
    for (int i = 0; i < 3; i++) r.clip[32*i +: 32] = o[i][31:0];
    return r;
  endfunction

  assign pending = clip_queue.size();

  // Track the register, queue predictions and compare result beats.
  always @(posedge clk) begin
    clip_res_t want;
    if (!rst_n) begin
      factor <= pvc_pkg::FACTOR_RESET;
      errors <= 0;
      clip_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) factor <= cfg_data;
      if (in_tvalid && in_tready) clip_queue.push_back(clip_velocity(in_tdata, factor));
      if (out_tvalid && out_tready) begin
        if (clip_queue.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat %h/%b", out_tdata, out_tuser);
        end else begin
          want = clip_queue.pop_front();
          if (want.clip !== out_tdata || want.clamped !== out_tuser[0]) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected %h/%b got %h/%b",
                       want.clip, want.clamped, out_tdata, out_tuser);
          end
        end
      end
    end
  end

endmodule

// ===== test/plane_velocity_clip_test.sv =====
module plane_velocity_clip_test;

  localparam int LATENCY = 108;
  localparam int RANDOM_BEATS = 1900;
  localparam longint CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  int           errors;
  int           pending;
  int           idle_pct;
  longint       cycles;

  plane_velocity_clip dut (.*);

  plane_velocity_clip_check check (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    if (!rst_n) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stalls at random, except during quiet stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic logic [31:0] pick_vel();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(2000000) - 1000000;
      3: return $urandom_range(200000000) - 100000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_norm();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return 16'($urandom_range(32768) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [143:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(input int count);
    logic [143:0] d;
    for (int i = 0; i < count; i++) begin
      d = {pick_norm(), pick_norm(), pick_norm(), pick_vel(), pick_vel(), pick_vel()};
      send_beat(d);
    end
    in_tvalid <= 1'b0;
  endtask

  // Write the overbounce factor once every result is back and the pipe is empty.
  task automatic write_factor(input logic [15:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] factors[6];
    factors = '{16'd4096, 16'd0, 16'd1, 16'hffff, 16'd4100, 16'd8192};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_data = '0;
    idle_pct = 29;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset factor: zero, extremes, unit normals, zero normal.
    send_beat('0);
    send_beat({16'h0000, 16'h0000, 16'sd16384, 32'd0, 32'd0, 32'h0001_0000});
    send_beat({16'h0000, 16'h0000, -16'sd16384, 32'd0, 32'd0, 32'h0001_0000});
    send_beat({16'h7fff, 16'h7fff, 16'h7fff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_beat({16'h8000, 16'h8000, 16'h8000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_beat({16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_beat({16'h7fff, 16'h8000, 16'h7fff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    send_beat({16'h0000, 16'h0000, 16'h0000, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff});
    send_beat({16'h2d41, 16'h2d41, 16'h0000, 32'hfffe_0000, 32'h0003_0000, 32'h0000_0000});
    send_beat({16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_random(10);

    // Walk the factor through its extremes, with noise and a quiet stretch.
    foreach (factors[k]) begin
      write_factor(factors[k]);
      idle_pct = (k == 2) ? 0 : 29;
      send_random(RANDOM_BEATS / 6);
    end
    idle_pct = 29;

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== plane_velocity_clip.f =====
src/pvc_pkg.sv
src/pvc_div.sv
src/pvc_sqrt.sv
src/pvc_front.sv
src/pvc_clip.sv
src/plane_velocity_clip.sv
test/plane_velocity_clip_check.sv
test/plane_velocity_clip_test.sv
